>>> design/wfpo_pkg.sv
// Types, constants and tables shared by the wheel frame parser and odometry unit.
`timescale 1ns / 1ps
package wfpo_pkg;

    localparam int DATA_BYTES = 8;

    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_SHARP   = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_BANG    = 8'h21;

    localparam logic CFG_BOGUS_LIMIT = 1'b0;
    localparam logic CFG_YAW_GAIN    = 1'b1;

    localparam logic [3:0]  BOGUS_LIMIT_RST = 4'd5;
    localparam logic [15:0] YAW_GAIN_RST    = 16'd11863;

    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic [31:0]        HEADING_MULT = 32'd2867080570;
    localparam logic signed [53:0] POS_MAX = 54'sd140737488355327;
    localparam logic signed [53:0] POS_MIN = -54'sd140737488355328;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_now_us;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        vel_x;
        logic signed [15:0] vel_y;
        logic signed [31:0] yaw_rate;
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [31:0]        heading;
    } t_out_item;

    typedef struct packed {
        logic [63:0] wheels;
        logic [31:0] stamp;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        PS_DOLLAR, PS_SHARP, PS_DATA, PS_PERCENT, PS_CLAIM
    } t_parse_st;

    typedef enum logic [2:0] {
        OS_IDLE, OS_LOAD, OS_CORDIC, OS_MUL, OS_WB, OS_FINAL
    } t_odo_st;

    typedef enum logic [3:0] {
        OP_YAW, OP_DX, OP_DY, OP_MAG, OP_LO, OP_HI,
        OP_XC_H, OP_XC_L, OP_YS_H, OP_YS_L, OP_XS_H, OP_XS_L, OP_YC_H, OP_YC_L
    } t_op;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        case (i)
            5'd0:  atan_val = 32'h20000000;
            5'd1:  atan_val = 32'h12E4051E;
            5'd2:  atan_val = 32'h09FB385B;
            5'd3:  atan_val = 32'h051111D4;
            5'd4:  atan_val = 32'h028B0D43;
            5'd5:  atan_val = 32'h0145D7E1;
            5'd6:  atan_val = 32'h00A2F61E;
            5'd7:  atan_val = 32'h00517C55;
            5'd8:  atan_val = 32'h0028BE53;
            5'd9:  atan_val = 32'h00145F2F;
            5'd10: atan_val = 32'h000A2F98;
            5'd11: atan_val = 32'h000517CC;
            5'd12: atan_val = 32'h00028BE6;
            5'd13: atan_val = 32'h000145F3;
            5'd14: atan_val = 32'h0000A2FA;
            5'd15: atan_val = 32'h0000517D;
            5'd16: atan_val = 32'h000028BE;
            5'd17: atan_val = 32'h0000145F;
            5'd18: atan_val = 32'h00000A30;
            5'd19: atan_val = 32'h00000518;
            5'd20: atan_val = 32'h0000028C;
            5'd21: atan_val = 32'h00000146;
            5'd22: atan_val = 32'h000000A3;
            5'd23: atan_val = 32'h00000051;
            5'd24: atan_val = 32'h00000029;
            5'd25: atan_val = 32'h00000014;
            5'd26: atan_val = 32'h0000000A;
            5'd27: atan_val = 32'h00000005;
            5'd28: atan_val = 32'h00000003;
            5'd29: atan_val = 32'h00000001;
            5'd30: atan_val = 32'h00000001;
            default: atan_val = 32'h00000000;
        endcase
    endfunction

endpackage

>>> design/wfpo_front.sv
// Byte framer: tracks the frame sequence, counts bogus bytes, pushes complete frames.
`timescale 1ns / 1ps
module wfpo_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wfpo_pkg::t_in_item i_in,
    input  logic [3:0]         i_bogus_limit,
    input  wfpo_pkg::t_q_status i_q,
    output logic               o_push,
    output wfpo_pkg::t_frame   o_frame
);
    import wfpo_pkg::*;

    t_parse_st  r_st, n_st;
    logic [3:0] r_idx, n_idx;
    logic [3:0] r_bog, n_bog;
    logic [7:0] r_buf [DATA_BYTES];
    logic       acc, wr;
    logic [4:0] bog_inc;
    logic       bog_trip;

    assign o_ready  = !i_q.full;
    assign acc      = i_valid && o_ready;
    assign bog_inc  = {1'b0, r_bog} + 5'd1;
    assign bog_trip = bog_inc > {1'b0, i_bogus_limit};

    always_comb begin
        n_st   = r_st;
        n_idx  = r_idx;
        n_bog  = r_bog;
        wr     = 1'b0;
        o_push = 1'b0;
        if (acc) begin
            case (r_st)
                PS_DATA: begin
                    wr    = 1'b1;
                    n_idx = r_idx + 4'd1;
                    if (n_idx >= 4'(DATA_BYTES)) n_st = PS_PERCENT;
                end
                PS_DOLLAR, PS_SHARP, PS_PERCENT, PS_CLAIM: begin
                    if (r_st == PS_DOLLAR && i_in.rx_byte == CH_DOLLAR) begin
                        n_st = PS_SHARP;
                    end else if (r_st == PS_SHARP && i_in.rx_byte == CH_SHARP) begin
                        n_st  = PS_DATA;
                        n_idx = 4'd0;
                    end else if (r_st == PS_PERCENT && i_in.rx_byte == CH_PERCENT) begin
                        n_st = PS_CLAIM;
                    end else if (r_st == PS_CLAIM && i_in.rx_byte == CH_BANG) begin
                        o_push = 1'b1;
                        n_st   = PS_DOLLAR;
                        n_idx  = 4'd0;
                    end else if (bog_trip) begin
                        // too many bad bytes: drop the partial frame
                        n_st  = PS_DOLLAR;
                        n_idx = 4'd0;
                        n_bog = 4'd0;
                    end else begin
                        n_bog = bog_inc[3:0];
                    end
                end
                default: begin
                    n_st  = PS_DOLLAR;
                    n_idx = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= PS_DOLLAR;
            r_idx <= 4'd0;
            r_bog <= 4'd0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
            r_bog <= n_bog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_buf[r_idx[2:0]] <= i_in.rx_byte;
    end

    always_comb begin
        for (int k = 0; k < DATA_BYTES; k++) o_frame.wheels[8*k +: 8] = r_buf[k];
        o_frame.stamp = i_in.time_now_us;
    end

endmodule

>>> design/wfpo_queue.sv
// Two-entry frame queue between the framer and the odometry sequencer.
`timescale 1ns / 1ps
module wfpo_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wfpo_pkg::t_frame    i_frame,
    input  logic                i_pop,
    output wfpo_pkg::t_frame    o_frame,
    output wfpo_pkg::t_q_status o_status
);
    import wfpo_pkg::*;

    t_frame     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_status.full  = r_cnt == 2'd2;
    assign o_status.empty = r_cnt == 2'd0;
    assign o_frame        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

>>> design/wfpo_back.sv
// Odometry sequencer: kinematics, CORDIC heading rotation and pose update on one multiplier.
`timescale 1ns / 1ps
module wfpo_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wfpo_pkg::t_q_status i_q,
    input  wfpo_pkg::t_frame    i_frame,
    output logic                o_pop,
    input  logic [15:0]         i_yaw_gain,
    output logic                o_valid,
    input  logic                i_ready,
    output wfpo_pkg::t_out_item o_out
);
    import wfpo_pkg::*;

    t_odo_st r_st, n_st;
    t_op     r_op;
    logic [4:0] r_step;
    t_frame  r_frm;

    logic [15:0]        r_vx, r_pvx;
    logic signed [15:0] r_vy, r_pvy;
    logic signed [17:0] r_d;
    logic signed [31:0] r_yr, r_pyr;
    logic [31:0]        r_last, r_dt, r_hd, r_inc;
    logic signed [47:0] r_px, r_py;
    logic signed [33:0] r_x, r_y, r_z;
    logic               r_neg;
    logic signed [48:0] r_dx, r_dy;
    logic [63:0]        r_p, r_lo;
    logic signed [65:0] r_prod, r_t1;
    logic signed [53:0] r_sx, r_sy;
    logic               r_ovalid;
    t_out_item          r_out;

    logic [17:0]        ul, ll, lr, ur;
    logic [17:0]        vsum;
    logic signed [17:0] vys;
    logic signed [33:0] ang, nx, ny;
    logic signed [32:0] m_a, m_b;
    logic signed [48:0] a_src;
    logic signed [33:0] c_src;
    logic [31:0]        mag;
    logic [63:0]        hi;
    logic signed [65:0] term;
    logic               out_free, last_step;
    logic [31:0]        hd_next;

    assign ul   = {2'b0, r_frm.wheels[15:0]};
    assign ll   = {2'b0, r_frm.wheels[31:16]};
    assign lr   = {2'b0, r_frm.wheels[47:32]};
    assign ur   = {2'b0, r_frm.wheels[63:48]};
    assign vsum = ul + ll + lr + ur;
    assign vys  = $signed(ll + lr - ul - ur);
    assign ang  = {{2{r_hd[31]}}, r_hd};
    assign mag  = r_pyr[31] ? 32'(-r_pyr) : 32'(r_pyr);

    assign out_free  = !r_ovalid || i_ready;
    assign last_step = r_step == 5'(CORDIC_STEPS - 1);
    assign o_pop     = (r_st == OS_IDLE) && !i_q.empty;
    assign o_valid   = r_ovalid;
    assign o_out     = r_out;

    // one CORDIC rotation
    always_comb begin
        if (!r_z[33]) begin
            nx = r_x - (r_y >>> r_step);
            ny = r_y + (r_x >>> r_step);
        end else begin
            nx = r_x + (r_y >>> r_step);
            ny = r_y - (r_x >>> r_step);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (r_op)
            OP_XC_H, OP_XC_L, OP_XS_H, OP_XS_L: a_src = r_dx;
            default:                            a_src = r_dy;
        endcase
        case (r_op)
            OP_YS_H, OP_YS_L, OP_XS_H, OP_XS_L: c_src = r_y;
            default:                            c_src = r_x;
        endcase
        case (r_op)
            OP_YAW: begin m_a = 33'(r_d);               m_b = {17'b0, i_yaw_gain}; end
            OP_DX:  begin m_a = {17'b0, r_pvx};        m_b = {1'b0, r_dt}; end
            OP_DY:  begin m_a = 33'(r_pvy);             m_b = {1'b0, r_dt}; end
            OP_MAG: begin m_a = {1'b0, mag};           m_b = {1'b0, r_dt}; end
            OP_LO:  begin m_a = {1'b0, r_p[31:0]};     m_b = {1'b0, HEADING_MULT}; end
            OP_HI:  begin m_a = {1'b0, r_p[63:32]};    m_b = {1'b0, HEADING_MULT}; end
            OP_XC_H, OP_YS_H, OP_XS_H, OP_YC_H: begin
                m_a = 33'(a_src >>> 24);
                m_b = 33'(c_src);
            end
            default: begin
                m_a = {9'b0, a_src[23:0]};
                m_b = 33'(c_src);
            end
        endcase
    end

    assign hi      = r_prod[63:0] + {32'b0, r_lo[63:32]};
    assign term    = (r_t1 + (r_prod >>> 24)) >>> 6;
    assign hd_next = r_pyr[31] ? r_hd - r_inc : r_hd + r_inc;

    always_comb begin
        n_st = r_st;
        case (r_st)
            OS_IDLE:   if (!i_q.empty) n_st = OS_LOAD;
            OS_LOAD:   n_st = OS_CORDIC;
            OS_CORDIC: if (last_step) n_st = OS_MUL;
            OS_MUL:    n_st = OS_WB;
            OS_WB:     n_st = (r_op == OP_YC_L) ? OS_FINAL : OS_MUL;
            OS_FINAL:  if (out_free) n_st = OS_IDLE;
            default:   n_st = OS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= OS_IDLE;
            r_ovalid <= 1'b0;
            r_pvx    <= '0;
            r_pvy    <= '0;
            r_pyr    <= '0;
            r_last   <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_hd     <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == OS_FINAL && out_free) begin
                r_ovalid <= 1'b1;
                r_pvx    <= r_vx;
                r_pvy    <= r_vy;
                r_pyr    <= r_yr;
                r_last   <= r_frm.stamp;
                r_hd     <= hd_next;
                r_px     <= (r_sx > POS_MAX) ? POS_MAX[47:0] :
                            (r_sx < POS_MIN) ? POS_MIN[47:0] : r_sx[47:0];
                r_py     <= (r_sy > POS_MAX) ? POS_MAX[47:0] :
                            (r_sy < POS_MIN) ? POS_MIN[47:0] : r_sy[47:0];
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            OS_IDLE: r_frm <= i_frame;
            OS_LOAD: begin
                r_vx   <= vsum[17:2];
                r_vy   <= 16'(vys >>> 2);
                r_d    <= $signed(lr + ur - ul - ll);
                r_dt   <= r_frm.stamp - r_last;
                r_x    <= CORDIC_START;
                r_y    <= '0;
                r_step <= 5'd0;
                // fold the heading into the right half plane
                if (ang > 34'sd1073741824) begin
                    r_z   <= ang - 34'sd2147483648;
                    r_neg <= 1'b1;
                end else if (ang < -34'sd1073741824) begin
                    r_z   <= ang + 34'sd2147483648;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= ang;
                    r_neg <= 1'b0;
                end
            end
            OS_CORDIC: begin
                r_step <= r_step + 5'd1;
                r_z    <= r_z[33] ? r_z + 34'(atan_val(r_step))
                                  : r_z - 34'(atan_val(r_step));
                if (last_step && r_neg) begin
                    r_x <= -nx;
                    r_y <= -ny;
                end else begin
                    r_x <= nx;
                    r_y <= ny;
                end
                r_op <= OP_YAW;
            end
            OS_MUL: r_prod <= m_a * m_b;
            OS_WB: begin
                case (r_op)
                    OP_YAW:  r_yr <= 32'(r_prod >>> 8);
                    OP_DX:   r_dx <= r_prod[48:0];
                    OP_DY:   r_dy <= r_prod[48:0];
                    OP_MAG:  r_p  <= r_prod[63:0];
                    OP_LO:   r_lo <= r_prod[63:0];
                    OP_HI:   r_inc <= hi[37:6];
                    OP_XC_L: r_sx <= 54'(r_px) + term[53:0];
                    OP_YS_L: r_sx <= r_sx - term[53:0];
                    OP_XS_L: r_sy <= 54'(r_py) + term[53:0];
                    OP_YC_L: r_sy <= r_sy + term[53:0];
                    default: r_t1 <= r_prod;
                endcase
                if (r_op != OP_YC_L) r_op <= t_op'(r_op + 4'd1);
            end
            OS_FINAL: begin
                if (out_free) begin
                    r_out.vel_x    <= r_vx;
                    r_out.vel_y    <= r_vy;
                    r_out.yaw_rate <= r_yr;
                    r_out.pos_x    <= (r_sx > POS_MAX) ? POS_MAX[47:0] :
                                      (r_sx < POS_MIN) ? POS_MIN[47:0] : r_sx[47:0];
                    r_out.pos_y    <= (r_sy > POS_MAX) ? POS_MAX[47:0] :
                                      (r_sy < POS_MIN) ? POS_MIN[47:0] : r_sy[47:0];
                    r_out.heading  <= hd_next;
                end
            end
            default: r_frm <= r_frm;
        endcase
    end

endmodule

>>> design/wheel_frame_parser_with_odometry_unit.sv
// Top level: configuration registers, framer, frame queue and odometry sequencer.
`timescale 1ns / 1ps
// Bytes are taken one per cycle while the two-entry frame queue has room. A byte that
// completes a frame ('!') yields one result. The sequencer takes a frame from the queue
// when idle, loads it, runs one CORDIC rotation per cycle, then fourteen steps, each a
// multiply state and a write-back state, on a single
// shared 33x33 multiplier (kinematics, travel, heading increment and four Q30 products
// split into high and low halves). The output register holds a result while the next
// frame is worked on. Configuration: index 0 is the bogus byte limit, index 1 the yaw gain.
module wheel_frame_parser_with_odometry_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  wfpo_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output wfpo_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import wfpo_pkg::*;

    logic [3:0]  r_bogus_limit;
    logic [15:0] r_yaw_gain;
    t_q_status   q_st;
    t_frame      push_frm, pop_frm;
    logic        push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bogus_limit <= BOGUS_LIMIT_RST;
            r_yaw_gain    <= YAW_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOGUS_LIMIT: r_bogus_limit <= i_cfg_data[3:0];
                CFG_YAW_GAIN:    r_yaw_gain    <= i_cfg_data;
                default:         r_yaw_gain    <= r_yaw_gain;
            endcase
        end
    end

    wfpo_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in          (i_in),
        .i_bogus_limit (r_bogus_limit),
        .i_q           (q_st),
        .o_push        (push),
        .o_frame       (push_frm)
    );

    wfpo_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_frame  (push_frm),
        .i_pop    (pop),
        .o_frame  (pop_frm),
        .o_status (q_st)
    );

    wfpo_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_st),
        .i_frame    (pop_frm),
        .o_pop      (pop),
        .i_yaw_gain (r_yaw_gain),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

endmodule
